// ----- sv/krt_pkg.sv -----
// Shared types and constants for the keyed reservation table.
// Holds the table sizes, opcode and status codes, and the request token
// that walks the row of cells. No dependencies.
package krt_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int KEY_BITS      = 64;
	localparam int VALUE_BITS    = 64;
	localparam int CLIENT_BITS   = 8;

	// beat field widths at the ports
	localparam int KEY_FLD_W    = 64;
	localparam int VALUE_FLD_W  = 64;
	localparam int CLIENT_FLD_W = 8;
	localparam int OP_FLD_W     = 3;
	localparam int STATUS_FLD_W = 3;
	localparam int OWNER_FLD_W  = 8;

	// client bits that survive both the port width and the masking
	localparam int CLI_W = (CLIENT_BITS < CLIENT_FLD_W) ? CLIENT_BITS : CLIENT_FLD_W;

	localparam int IN_TDATA_W  = ((KEY_FLD_W + VALUE_FLD_W + CLIENT_FLD_W + 7) / 8) * 8;
	localparam int OUT_USED_W  = VALUE_FLD_W + 1 + OWNER_FLD_W;
	localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

	typedef enum logic [OP_FLD_W-1:0] {
		OP_CREATE      = 3'd0,
		OP_WRITE       = 3'd1,
		OP_READ        = 3'd2,
		OP_RESERVE     = 3'd3,
		OP_RELEASE     = 3'd4,
		OP_RELEASE_ALL = 3'd5
	} krt_op_t;

	typedef enum logic [STATUS_FLD_W-1:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_DUP     = 3'd2,
		ST_MISSING = 3'd3,
		ST_TAKEN   = 3'd4,
		ST_FREE    = 3'd5,
		ST_FOREIGN = 3'd6
	} krt_status_t;

	// request plus what the cells found so far
	typedef struct packed {
		krt_op_t                op;
		logic [KEY_BITS-1:0]    key;
		logic [VALUE_BITS-1:0]  val;
		logic [CLI_W-1:0]       cli;
		logic                   matched;   // first matching entry already passed
		logic                   seen_free; // an empty cell was passed
		logic                   res;       // reserved flag of the hit entry
		logic [CLI_W-1:0]       owner;     // its owner, zero when not reserved
		logic [VALUE_BITS-1:0]  vout;
		krt_status_t            status;
	} krt_tok_t;

endpackage

// ----- sv/krt_cell.sv -----
// One table entry of the keyed reservation table plus its token stage.
// Acts on the request token passing by, then registers it for the next cell.
// Depends on krt_pkg.
module krt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_v,
	input  krt_pkg::krt_tok_t in_tok,
	input  logic              hold,     // keep the token here (last cell only)
	output logic              out_v,
	output krt_pkg::krt_tok_t out_tok,
	output logic              live,     // entry holds a created key
	output logic              held      // entry reserved
);

	logic                            live_q;
	logic                            res_q;
	logic [krt_pkg::KEY_BITS-1:0]    key_q;
	logic [krt_pkg::VALUE_BITS-1:0]  val_q;
	logic [krt_pkg::CLI_W-1:0]       own_q;
	logic                            v_q;
	krt_pkg::krt_tok_t               tok_q;

	krt_pkg::krt_tok_t nxt;
	logic hit;
	logic ins;
	logic val_we;
	logic res_set;
	logic res_clr;

	always_comb begin
		nxt     = in_tok;
		ins     = 1'b0;
		val_we  = 1'b0;
		res_set = 1'b0;
		res_clr = 1'b0;
		hit     = in_v && live_q && !in_tok.matched && (key_q == in_tok.key);

		// create lands in the first empty cell, unless a duplicate was seen
		if (in_v && in_tok.op == krt_pkg::OP_CREATE && !live_q && !in_tok.seen_free) begin
			nxt.seen_free = 1'b1;
			ins           = !in_tok.matched;
		end

		if (hit) begin
			nxt.matched = 1'b1;
			nxt.res     = res_q;
			nxt.owner   = res_q ? own_q : '0;
			case (in_tok.op)
				krt_pkg::OP_WRITE: begin
					val_we = 1'b1;
				end
				krt_pkg::OP_READ: begin
					nxt.vout = val_q;
				end
				krt_pkg::OP_RESERVE: begin
					if (res_q) begin
						nxt.status = krt_pkg::ST_TAKEN;
					end else begin
						res_set   = 1'b1;
						nxt.res   = 1'b1;
						nxt.owner = in_tok.cli;
					end
				end
				krt_pkg::OP_RELEASE: begin
					if (!res_q) begin
						nxt.status = krt_pkg::ST_FREE;
					end else if (own_q != in_tok.cli) begin
						nxt.status = krt_pkg::ST_FOREIGN;
					end else begin
						res_clr   = 1'b1;
						nxt.res   = 1'b0;
						nxt.owner = '0;
					end
				end
				default: begin
				end
			endcase
		end

		// release all visits every entry, not only the first hit
		if (in_v && in_tok.op == krt_pkg::OP_RELEASE_ALL && res_q && own_q == in_tok.cli) begin
			res_clr = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			res_q  <= 1'b0;
			v_q    <= 1'b0;
		end else begin
			if (ins) begin
				live_q <= 1'b1;
			end
			if (ins || res_clr) begin
				res_q <= 1'b0;
			end else if (res_set) begin
				res_q <= 1'b1;
			end
			v_q <= in_v | (hold & v_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			key_q <= in_tok.key;
		end
		if (ins || val_we) begin
			val_q <= in_tok.val;
		end
		if (res_set) begin
			own_q <= in_tok.cli;
		end
		if (in_v) begin
			tok_q <= nxt;
		end
	end

	assign out_v   = v_q;
	assign out_tok = tok_q;
	assign live    = live_q;
	assign held    = res_q;

endmodule

// ----- sv/keyed_reservation_table.sv -----
// Top level of the keyed reservation table: input beat, row of entry cells,
// result register. Depends on krt_pkg and krt_cell.
//
// Usage:
//  - s_axis carries one request per beat: tuser is the opcode, tdata packs
//    key, value_in and client. m_axis returns exactly one result per request:
//    tuser is the status code, tdata packs value_out, is_reserved and owner.
//  - A request token enters cell 0 on the accepting edge and moves one cell
//    per cycle down the row; each cell compares its key and applies the
//    opcode to its own entry as the token passes. The result register loads
//    from the last cell, so a result shows once the token has passed every
//    cell.
//  - One request is in the row at a time: s_axis_tready is high only while
//    the row is empty, so a new request is taken only after the last one
//    has left the cell row.
//  - The result register decouples the sides: a new request is taken while
//    an earlier result still waits on m_axis. If the receiver stalls, the
//    next token parks in the last cell until the result register frees up.
//  - Reset (arst_n low) empties the table: no entries, nothing reserved,
//    no token in flight and no result pending.
module keyed_reservation_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [63:0] key, [127:64] value_in, [135:128] client
	input  logic [krt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// [2:0] opcode
	input  logic [krt_pkg::OP_FLD_W-1:0]     s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [63:0] value_out, [64] is_reserved, [72:65] owner, [79:73] zero
	output logic [krt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// [2:0] status
	output logic [krt_pkg::STATUS_FLD_W-1:0] m_axis_tuser
);

	localparam int N = krt_pkg::TABLE_ENTRIES;
	localparam int VAL_OFF = krt_pkg::KEY_FLD_W;
	localparam int CLI_OFF = krt_pkg::KEY_FLD_W + krt_pkg::VALUE_FLD_W;

	logic [N-1:0]      stage_v;
	krt_pkg::krt_tok_t stage_tok [N];
	logic [N-1:0]      live_vec;
	logic [N-1:0]      held_vec;

	krt_pkg::krt_tok_t tok_in;
	logic              in_beat;
	logic              hold_last;
	logic              load_out;

	// result register
	logic                                  out_v_q;
	krt_pkg::krt_status_t                  status_q;
	logic [krt_pkg::VALUE_FLD_W-1:0]       vout_q;
	logic                                  res_q;
	logic [krt_pkg::OWNER_FLD_W-1:0]       owner_q;

	krt_pkg::krt_tok_t                     fin;
	krt_pkg::krt_status_t                  fin_status;
	logic                                  fin_res;

	assign s_axis_tready = ~(|stage_v);
	assign in_beat       = s_axis_tvalid & s_axis_tready;

	// fresh token from the beat; fields masked to the table widths
	always_comb begin
		tok_in           = '0;
		tok_in.op        = krt_pkg::krt_op_t'(s_axis_tuser);
		tok_in.key       = s_axis_tdata[krt_pkg::KEY_BITS-1:0];
		tok_in.val       = s_axis_tdata[VAL_OFF +: krt_pkg::VALUE_BITS];
		tok_in.cli       = s_axis_tdata[CLI_OFF +: krt_pkg::CLI_W];
		tok_in.status    = krt_pkg::ST_OK;
	end

	assign hold_last = out_v_q & ~m_axis_tready;
	assign load_out  = stage_v[N-1] & ~hold_last;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic              c_in_v;
		krt_pkg::krt_tok_t c_in_tok;
		logic              c_hold;

		if (i == 0) begin : g_head
			assign c_in_v   = in_beat;
			assign c_in_tok = tok_in;
		end else begin : g_body
			assign c_in_v   = stage_v[i-1];
			assign c_in_tok = stage_tok[i-1];
		end

		assign c_hold = (i == N - 1) ? hold_last : 1'b0;

		krt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_v    (c_in_v),
			.in_tok  (c_in_tok),
			.hold    (c_hold),
			.out_v   (stage_v[i]),
			.out_tok (stage_tok[i]),
			.live    (live_vec[i]),
			.held    (held_vec[i])
		);
	end

	// settle the status once the token has seen every entry
	always_comb begin
		fin        = stage_tok[N-1];
		fin_status = fin.status;
		fin_res    = fin.res;
		case (fin.op)
			krt_pkg::OP_CREATE: begin
				if (!fin.seen_free) begin
					// full is reported ahead of a duplicate key
					fin_status = krt_pkg::ST_FULL;
					fin_res    = 1'b0;
				end else if (fin.matched) begin
					fin_status = krt_pkg::ST_DUP;
				end else begin
					fin_status = krt_pkg::ST_OK;
				end
			end
			krt_pkg::OP_WRITE, krt_pkg::OP_READ, krt_pkg::OP_RESERVE,
			krt_pkg::OP_RELEASE: begin
				if (!fin.matched) begin
					fin_status = krt_pkg::ST_MISSING;
				end
			end
			default: begin
				// release all and unused opcodes address no single entry
				fin_status = krt_pkg::ST_OK;
				fin_res    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= fin_status;
			vout_q   <= krt_pkg::VALUE_FLD_W'(fin.vout);
			res_q    <= fin_res;
			owner_q  <= fin_res ? krt_pkg::OWNER_FLD_W'(fin.owner) : '0;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {(krt_pkg::OUT_TDATA_W - krt_pkg::OUT_USED_W)'(0),
		owner_q, res_q, vout_q};

`ifndef SYNTHESIS
	// never more than one request in the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(stage_v))
		else $error("more than one token in the cell row");

	// live entries always form a prefix from cell 0
	a_live_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((live_vec + N'(1)) & live_vec) == '0)
		else $error("live entries not contiguous");

	// only live entries can be reserved
	a_held_live: assert property (@(posedge clk) disable iff (!arst_n)
		(held_vec & ~live_vec) == '0)
		else $error("reserved flag on an empty entry");

	// an accepted request enters cell 0 next cycle
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> stage_v[0])
		else $error("accepted request lost at cell 0");

	// a token leaving the row always lands in the result register
	a_leave: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> m_axis_tvalid && !stage_v[N-1])
		else $error("token not moved to the result register");
`endif

endmodule
